// ----- sv/bfi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared types and constants of the bloom filter insert block: filter geometry,
// hash seeds, field widths, mode and status codes, and the command word that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bfi_pkg;

  // filter geometry
  localparam int FILTER_BITS = 16384;
  localparam int WORD_W      = 32;
  localparam int WORD_COUNT  = FILTER_BITS / WORD_W;
  localparam int WORD_AW     = $clog2(WORD_COUNT);
  localparam int BIT_AW      = $clog2(WORD_W);
  localparam int POS_W       = $clog2(FILTER_BITS);

  // hashing
  localparam int SEED_COUNT = 4;
  localparam int HIDX_W     = $clog2(SEED_COUNT);
  localparam int HASH_W     = 32;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [SEED_COUNT-1:0][HASH_W-1:0] SEEDS = {
    32'h9876_5432, 32'habcd_ef12, 32'h76a5_4d32, 32'h15a4_db35
  };

  // word fields
  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int WIDX_W   = 9;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // key length tracking
  localparam logic [LEN_W-1:0] COUNT_SAT = 7'd65;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd35;

  // input modes
  localparam logic [MODE_W-1:0] MODE_KEY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LEN_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_READ     = 2'd2;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_ERROR,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                              op;
    logic [SEED_COUNT-1:0][POS_W-1:0] pos;
    logic [WIDX_W-1:0]                widx;
  } cmd_t;

endpackage

// ----- sv/bfi_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi channel interfaces
// Valid/ready channels of the bloom filter insert block: the key byte input,
// the result output and the length register write port.
// ----------------------------------------------------------------------------
interface bfi_item_if import bfi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] key_byte;
  logic              last_byte;
  logic [WIDX_W-1:0] word_index;

  modport source(output valid, mode, key_byte, last_byte, word_index, input ready);
  modport sink(input valid, mode, key_byte, last_byte, word_index, output ready);
endinterface

interface bfi_result_if import bfi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    bit_pos_a;
  logic [POS_W-1:0]    bit_pos_b;
  logic [POS_W-1:0]    bit_pos_c;
  logic [POS_W-1:0]    bit_pos_d;
  logic [WORD_W-1:0]   filter_word;

  modport source(output valid, status, bit_pos_a, bit_pos_b, bit_pos_c, bit_pos_d,
                 filter_word, input ready);
  modport sink(input valid, status, bit_pos_a, bit_pos_b, bit_pos_c, bit_pos_d,
               filter_word, output ready);
endinterface

interface bfi_cfg_if import bfi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] expected_length;

  modport source(output valid, expected_length, input ready);
  modport sink(input valid, expected_length, output ready);
endinterface

// ----- sv/bfi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_front
// Front end: takes input words, runs four FNV-1a hashes one byte a cycle when
// not stalled, counts key bytes, checks length at key end, queues commands.
// ----------------------------------------------------------------------------
module bfi_front import bfi_pkg::*; #(
  parameter int NUM_HASHES = 4
) (
  input  logic       clk,
  input  logic       rst,
  bfi_item_if.sink   item,
  bfi_cfg_if.sink    cfg,
  input  logic       init_done,
  output cmd_t       push_cmd,
  output logic       push_valid,
  input  logic       push_ready
);

  localparam int USED_HASHES = (NUM_HASHES < SEED_COUNT) ? NUM_HASHES : SEED_COUNT;

  logic [HASH_W-1:0] hash [SEED_COUNT];
  logic [HASH_W-1:0] hash_mul [SEED_COUNT];
  logic [LEN_W-1:0]  byte_count;
  logic [LEN_W-1:0]  count_inc;
  logic [LEN_W-1:0]  expected_length;
  logic              accepted;
  logic              key_end;
  logic              len_ok;

  // handshakes
  assign item.ready = push_ready && init_done;
  assign cfg.ready  = 1'b1;
  assign accepted   = item.valid && item.ready;

  // per-seed hash update
  always_comb begin
    for (int i = 0; i < SEED_COUNT; i++) begin
      hash_mul[i] = HASH_W'((hash[i] ^ {{(HASH_W-BYTE_W){1'b0}}, item.key_byte}) * FNV_PRIME);
    end
  end

  // saturating byte count and length check
  assign count_inc = (byte_count < COUNT_SAT) ? byte_count + 7'd1 : byte_count;
  assign len_ok    = (count_inc == expected_length);
  assign key_end   = (item.mode == MODE_KEY) && item.last_byte;

  // command to the back end
  always_comb begin
    push_valid    = 1'b0;
    push_cmd.op   = OP_READ;
    push_cmd.pos  = '0;
    push_cmd.widx = item.word_index;
    case (item.mode)
      MODE_KEY: begin
        push_valid  = accepted && item.last_byte;
        push_cmd.op = len_ok ? OP_INSERT : OP_ERROR;
        if (len_ok) begin
          for (int i = 0; i < USED_HASHES; i++) begin
            push_cmd.pos[i] = hash_mul[i][POS_W-1:0];
          end
        end
      end
      MODE_CLEAR: begin
        push_valid  = accepted;
        push_cmd.op = OP_CLEAR;
      end
      MODE_READ: begin
        push_valid  = accepted;
        push_cmd.op = OP_READ;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  // hash state, byte count and length register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEED_COUNT; i++) begin
        hash[i] <= SEEDS[i];
      end
      byte_count      <= '0;
      expected_length <= LEN_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        expected_length <= cfg.expected_length;
      end
      if (accepted) begin
        if (key_end || item.mode == MODE_CLEAR) begin
          for (int i = 0; i < SEED_COUNT; i++) begin
            hash[i] <= SEEDS[i];
          end
          byte_count <= '0;
        end else if (item.mode == MODE_KEY) begin
          for (int i = 0; i < SEED_COUNT; i++) begin
            hash[i] <= hash_mul[i];
          end
          byte_count <= count_inc;
        end
      end
    end
  end

  // a clear or key end restarts the key
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accepted && (item.mode == MODE_CLEAR || key_end)
    |=> byte_count == '0 && hash[0] == SEEDS[0])
    else $error("key state not restarted");

  // nothing is queued before the initial clearing pass ends
  a_no_early_push: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> init_done)
    else $error("command queued during initial clear");

endmodule

// ----- sv/bfi_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_queue
// Short command queue between the front and back ends, so that hashing goes
// on while the back end works on the filter memory.
// ----------------------------------------------------------------------------
module bfi_queue import bfi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/bfi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_back
// Back end: owns the filter memory, sweeps it clear after reset and on a clear
// command, sets hash bits by read-modify-write and holds the result register.
// ----------------------------------------------------------------------------
module bfi_back import bfi_pkg::*; #(
  parameter int NUM_HASHES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       pop_cmd,
  input  logic       pop_valid,
  output logic       pop_ready,
  output logic       init_done,
  bfi_result_if.source result
);

  localparam int USED_HASHES = (NUM_HASHES < SEED_COUNT) ? NUM_HASHES : SEED_COUNT;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_WR    = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [WORD_W-1:0]   mem [WORD_COUNT];
  logic [WORD_W-1:0]   rd_data;
  logic [WORD_AW-1:0]  clr_addr;
  logic [HIDX_W-1:0]   hidx;
  cmd_t                cmd;
  logic                take;
  logic                clr_last;
  logic                hash_last;
  logic [POS_W-1:0]    cur_pos;
  logic                mem_we;
  logic [WORD_AW-1:0]  mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [WORD_AW-1:0]  mem_raddr;
  logic                out_free;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SEED_COUNT-1:0][POS_W-1:0] out_pos;
  logic [WORD_W-1:0]   out_word;

  assign pop_ready = (state == S_IDLE);
  assign take      = pop_valid && pop_ready;
  assign clr_last  = (clr_addr == WORD_AW'(WORD_COUNT - 1));
  assign hash_last = (hidx == HIDX_W'(USED_HASHES - 1));
  assign cur_pos   = cmd.pos[hidx];
  assign out_free  = !out_valid || result.ready;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cur_pos[POS_W-1:BIT_AW];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_re    = take && (pop_cmd.op == OP_READ);
        mem_raddr = pop_cmd.widx[WORD_AW-1:0];
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_pos[POS_W-1:BIT_AW];
        mem_wdata = rd_data | (WORD_W'(1) << cur_pos[BIT_AW-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // filter memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          case (pop_cmd.op)
            OP_CLEAR:  state_next = S_CLEAR;
            OP_INSERT: state_next = S_RD;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        state_next = hash_last ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      init_done <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_last) init_done <= 1'b1;
      end
    end
  end

  // current command and hash index
  always_ff @(posedge clk) begin
    if (take) begin
      cmd  <= pop_cmd;
      hidx <= '0;
    end else if (state == S_WR) begin
      hidx <= hidx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      case (cmd.op)
        OP_INSERT: out_status <= ST_INSERTED;
        OP_READ:   out_status <= ST_READ;
        default:   out_status <= ST_LEN_ERR;
      endcase
      out_pos  <= cmd.pos;
      out_word <= (cmd.op == OP_READ) ? rd_data : '0;
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.bit_pos_a   = out_pos[0];
  assign result.bit_pos_b   = out_pos[1];
  assign result.bit_pos_c   = out_pos[2];
  assign result.bit_pos_d   = out_pos[3];
  assign result.filter_word = out_word;

  // the sweep writes zeros
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> mem_we && mem_wdata == '0)
    else $error("clearing sweep wrote non-zero data");

  // an insert starts its read-modify-write at once
  a_insert_start: assert property (@(posedge clk) disable iff (rst)
    take && pop_cmd.op == OP_INSERT |=> state == S_RD)
    else $error("insert did not start bit update");

  // every write-back follows its read
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> $past(state == S_RD))
    else $error("write-back without preceding read");

  // before the first sweep ends the back end only clears
  a_init_clear: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> state == S_CLEAR)
    else $error("work before initial clear finished");

endmodule

// ----- sv/bloom_filter_insert_fnv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_insert_fnv
// Bloom filter builder: key bytes stream in, four seeded FNV-1a hashes pick
// the bits to set at each key end; clear and word read commands share the
// input channel.
// ----------------------------------------------------------------------------
// channel   dir  handshake     word
// item      in   valid/ready   mode, key_byte, last_byte, word_index
// result    out  valid/ready   status, bit_pos_a..d, filter_word
// cfg       in   valid/ready   expected_length (always ready)
//
// key bytes are taken one a cycle while item.ready is high; hashing runs in
// the front end, filter updates in the back end behind a four-entry command
// queue. an inserting key end holds the back end while it takes the command,
// reads and writes back a filter word for each hash in use and loads the
// result; a length error or a word read holds it to take the command and load
// the result. reset starts a clearing sweep of all 512 filter words during
// which item.ready is low; a clear command repeats the sweep. item.ready drops
// when the queue is full; a stalled result holds the back end but the front
// end keeps hashing until the queue fills.
// ----------------------------------------------------------------------------
module bloom_filter_insert_fnv import bfi_pkg::*; #(
  parameter int NUM_HASHES = 4
) (
  input  logic         clk,
  input  logic         rst,
  bfi_item_if.sink     item,
  bfi_result_if.source result,
  bfi_cfg_if.sink      cfg
);

  cmd_t push_cmd;
  logic push_valid;
  logic push_ready;
  cmd_t pop_cmd;
  logic pop_valid;
  logic pop_ready;
  logic init_done;

  bfi_front #(
    .NUM_HASHES(NUM_HASHES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .init_done  (init_done),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  bfi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  bfi_back #(
    .NUM_HASHES(NUM_HASHES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .init_done (init_done),
    .result    (result)
  );

endmodule
